@@ design/lpgw_pkg.sv @@
// ----------------------------------------------------------------------------
// lpgw_pkg
// types, codes and constants shared by the lcd window/glyph writer files
// ----------------------------------------------------------------------------
package lpgw_pkg;

  // action codes of an input item; other codes emit nothing
  typedef enum logic [2:0] {
    ACT_WINDOW = 3'd0,
    ACT_PIXEL  = 3'd1,
    ACT_GLYPH  = 3'd2,
    ACT_CMD    = 3'd3,
    ACT_PARAM  = 3'd4
  } lpgw_action_e;

  // register indexes of the configuration port
  typedef enum logic {
    REG_FG_COLOR = 1'b0,
    REG_BG_COLOR = 1'b1
  } lpgw_reg_e;

  localparam logic [7:0]  CMD_COLUMN_ADDR  = 8'h2A;
  localparam logic [7:0]  CMD_ROW_ADDR     = 8'h2B;
  localparam logic [7:0]  CMD_MEMORY_WRITE = 8'h2C;
  localparam logic [7:0]  ADDR_HIGH_BYTE   = 8'h00;
  localparam logic [15:0] FG_RESET         = 16'hFFE0;
  localparam logic [15:0] BG_RESET         = 16'h0000;

  // write counts per action
  localparam logic [4:0] LEN_WINDOW = 5'd11;
  localparam logic [4:0] LEN_PIXEL  = 5'd2;
  localparam logic [4:0] LEN_GLYPH  = 5'd16;
  localparam logic [4:0] LEN_SINGLE = 5'd1;
  localparam logic [4:0] LEN_NONE   = 5'd0;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  x_start;
    logic [7:0]  y_start;
    logic [7:0]  x_end;
    logic [7:0]  y_end;
    logic [15:0] color;
    logic [7:0]  glyph_bits;
    logic [7:0]  raw_byte;
  } lpgw_in_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } lpgw_out_t;

  typedef struct packed {
    logic [15:0] fg;
    logic [15:0] bg;
  } lpgw_colors_t;

  // number of bus writes that an action causes
  function automatic logic [4:0] lpgw_len(input logic [2:0] action);
    logic [4:0] len;
    unique case (action)
      ACT_WINDOW:         len = LEN_WINDOW;
      ACT_PIXEL:          len = LEN_PIXEL;
      ACT_GLYPH:          len = LEN_GLYPH;
      ACT_CMD, ACT_PARAM: len = LEN_SINGLE;
      default:            len = LEN_NONE;
    endcase
    return len;
  endfunction

endpackage

@@ design/lpgw_cfg.sv @@
// ----------------------------------------------------------------------------
// lpgw_cfg
// apb register file holding the glyph foreground and background colors
// ----------------------------------------------------------------------------
module lpgw_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output lpgw_pkg::lpgw_colors_t colors_o
);
  import lpgw_pkg::*;

  logic [15:0] fg_q, fg_d;
  logic [15:0] bg_q, bg_d;
  logic        wr_en;
  lpgw_reg_e   reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = lpgw_reg_e'(paddr[2]);

  always_comb begin
    fg_d = fg_q;
    bg_d = bg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_FG_COLOR: fg_d = pwdata[15:0];
        REG_BG_COLOR: bg_d = pwdata[15:0];
        default:      fg_d = fg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FG_RESET;
      bg_q <= BG_RESET;
    end else begin
      fg_q <= fg_d;
      bg_q <= bg_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FG_COLOR: prdata = {16'h0000, fg_q};
      REG_BG_COLOR: prdata = {16'h0000, bg_q};
      default:      prdata = 32'h0000_0000;
    endcase
  end

  assign colors_o = '{fg: fg_q, bg: bg_q};

endmodule

@@ design/lpgw_byte_gen.sv @@
// ----------------------------------------------------------------------------
// lpgw_byte_gen
// selects the bus write at a given position of an item's write sequence
// ----------------------------------------------------------------------------
module lpgw_byte_gen (
  input  lpgw_pkg::lpgw_in_t     item_i,
  input  logic [3:0]             idx_i,
  input  lpgw_pkg::lpgw_colors_t colors_i,
  output lpgw_pkg::lpgw_out_t    wr_o
);
  import lpgw_pkg::*;

  logic [4:0]  len;
  logic [2:0]  bit_sel;
  logic        glyph_bit;
  logic [15:0] glyph_color;
  logic [15:0] pix_color;

  assign len         = lpgw_len(item_i.action);
  // glyph pixel n covers writes 2n and 2n+1, msb first
  assign bit_sel     = 3'd7 - idx_i[3:1];
  assign glyph_bit   = item_i.glyph_bits[bit_sel];
  assign glyph_color = glyph_bit ? colors_i.fg : colors_i.bg;
  assign pix_color   = (item_i.action == ACT_GLYPH) ? glyph_color : item_i.color;

  always_comb begin
    wr_o.is_data  = 1'b1;
    wr_o.bus_byte = 8'h00;
    wr_o.last     = ({1'b0, idx_i} == (len - 5'd1));
    unique case (item_i.action)
      ACT_WINDOW: begin
        unique case (idx_i)
          4'd0: begin
            wr_o.is_data  = 1'b0;
            wr_o.bus_byte = CMD_COLUMN_ADDR;
          end
          4'd2:    wr_o.bus_byte = item_i.x_start;
          4'd4:    wr_o.bus_byte = item_i.x_end - 8'd1;
          4'd5: begin
            wr_o.is_data  = 1'b0;
            wr_o.bus_byte = CMD_ROW_ADDR;
          end
          4'd7:    wr_o.bus_byte = item_i.y_start;
          4'd9:    wr_o.bus_byte = item_i.y_end - 8'd1;
          4'd10: begin
            wr_o.is_data  = 1'b0;
            wr_o.bus_byte = CMD_MEMORY_WRITE;
          end
          default: wr_o.bus_byte = ADDR_HIGH_BYTE;
        endcase
      end
      ACT_PIXEL, ACT_GLYPH: begin
        wr_o.bus_byte = idx_i[0] ? pix_color[7:0] : pix_color[15:8];
      end
      ACT_CMD: begin
        wr_o.is_data  = 1'b0;
        wr_o.bus_byte = item_i.raw_byte;
      end
      ACT_PARAM: wr_o.bus_byte = item_i.raw_byte;
      default:   wr_o.bus_byte = 8'h00;
    endcase
  end

endmodule

@@ design/lcd_parallel_window_glyph_writer_core.sv @@
// ----------------------------------------------------------------------------
// lcd_parallel_window_glyph_writer_core
// 8080-style 8-bit lcd write engine: window setup, pixels, glyph bytes, raw
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  in       | input     | in_valid_i / in_stall_o  | lpgw_in_t operation
//  out      | output    | out_valid_o / out_stall_i| lpgw_out_t bus write
//  cfg      | input     | apb psel/penable/pready  | fg_color, bg_color
//
//  one bus write leaves per cycle while the output is not stalled; an item
//  has as many writes as its action: 11 for set window, 2 for a pixel, 16 for
//  a glyph byte, 1 for raw bytes and none for an unknown action
//  the next item is taken in the cycle its last write moves to the output
//  register, so items follow with no gap; reset clears the valid flags and
//  the write index
//  a stalled output holds its write and the item register waits behind it
//
module lcd_parallel_window_glyph_writer_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // operation input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lpgw_pkg::lpgw_in_t in_data_i,
  // bus write output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lpgw_pkg::lpgw_out_t out_data_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lpgw_pkg::*;

  // item register and its write index
  lpgw_in_t     item_q, item_d;
  logic         hold_vld_q, hold_vld_d;
  logic [3:0]   idx_q, idx_d;
  // output register
  lpgw_out_t    out_q, out_d;
  logic         out_vld_q, out_vld_d;

  lpgw_colors_t colors;
  lpgw_out_t    gen_wr;
  logic         out_load;
  logic         in_fire;

  lpgw_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .colors_o (colors)
  );

  lpgw_byte_gen u_gen (
    .item_i   (item_q),
    .idx_i    (idx_q),
    .colors_i (colors),
    .wr_o     (gen_wr)
  );

  // output register takes a write when empty or being drained
  assign out_load   = hold_vld_q && (!out_vld_q || !out_stall_i);
  // item register frees up as its last write moves out
  assign in_stall_o = hold_vld_q && !(out_load && gen_wr.last);
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    item_d     = item_q;
    hold_vld_d = hold_vld_q;
    idx_d      = idx_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && out_stall_i;
    if (out_load) begin
      out_d     = gen_wr;
      out_vld_d = 1'b1;
      idx_d     = idx_q + 4'd1;
      if (gen_wr.last) begin
        hold_vld_d = 1'b0;
      end
    end
    if (in_fire) begin
      item_d     = in_data_i;
      idx_d      = 4'd0;
      // unknown actions cause no writes and never occupy the register
      hold_vld_d = (lpgw_len(in_data_i.action) != LEN_NONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      idx_q      <= 4'd0;
    end else begin
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
      idx_q      <= idx_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // a held item never runs past its write count
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> ({1'b0, idx_q} < lpgw_len(item_q.action)))
    else $error("write index beyond item length");

  // an accepted known action starts at the first write
  a_start_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (lpgw_len(in_data_i.action) != LEN_NONE) |=> hold_vld_q && (idx_q == 4'd0))
    else $error("new item did not start at write zero");

  // a write that is not the last moves on to the next index of the same item
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !gen_wr.last |=> hold_vld_q && (idx_q == $past(idx_q) + 4'd1))
    else $error("write index did not advance");

  // a write is only generated into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && (out_q == $past(out_q)))
    else $error("stalled bus write overwritten");

endmodule

@@ bench/lcd_parallel_window_glyph_writer_core_test.sv @@
// ----------------------------------------------------------------------------
// lcd_parallel_window_glyph_writer_core_test
// self-checking bench for the lcd write engine: display operations go in on
// the input channel, every bus write that comes out is checked in order
// against writes predicted from the operation and the color registers
// ----------------------------------------------------------------------------
module lcd_parallel_window_glyph_writer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpgw_pkg::*;

  // bus select values of a write
  localparam logic IS_CMD  = 1'b0;
  localparam logic IS_DATA = 1'b1;

  // action codes the block does not define, they must emit nothing
  localparam logic [2:0] ACT_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNKNOWN_LAST  = 3'd7;

  // longest item is a glyph byte with 16 writes, give some margin on top
  localparam int DRAIN_CYCLES = 24;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_OPS    = 55;

  // receiver behavior per phase
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_BURSTY
  } stall_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  lpgw_in_t    in_data = '0;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  logic        in_stall;
  logic        out_valid;
  lpgw_out_t   out_data;
  logic [31:0] prdata;
  logic        pready;

  // shadow copy of the color registers
  logic [15:0] fg_shadow = FG_RESET;
  logic [15:0] bg_shadow = BG_RESET;

  // bus writes predicted but not yet seen on the output
  lpgw_out_t   pending_writes[$];

  stall_mode_e stall_mode = STALL_NONE;
  int          error_count = 0;
  int          ops_sent = 0;
  int          writes_checked = 0;
  int          color_settings = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  lcd_parallel_window_glyph_writer_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog, also counts cycles for the summary
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $error("timeout after %0d cycles, %0d writes still pending", cycle_count,
             pending_writes.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stall pattern, changes on the falling edge only
  initial begin : out_stall_pattern
    int  run;
    logic stall_now;
    run = 0;
    stall_now = 1'b0;
    forever begin
      @(negedge clk);
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_LIGHT: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          // alternating runs of stall and flow, random lengths
          if (run == 0) begin
            stall_now = !stall_now;
            run = stall_now ? $urandom_range(1, 8) : $urandom_range(1, 12);
          end
          run--;
          out_stall <= stall_now;
        end
      endcase
    end
  end

  function automatic lpgw_out_t bus_write(input logic is_data, input logic [7:0] value);
    lpgw_out_t w;
    w.is_data  = is_data;
    w.bus_byte = value;
    w.last     = 1'b0;
    return w;
  endfunction

  // work out every bus write one operation causes and queue them in order
  function automatic void predict_writes(input lpgw_in_t op);
    lpgw_out_t   w[16];
    int          n;
    logic [15:0] px;
    n = 0;
    case (op.action)
      ACT_WINDOW: begin
        // column range, row range, then memory write; ends are exclusive
        w[0]  = bus_write(IS_CMD, CMD_COLUMN_ADDR);
        w[1]  = bus_write(IS_DATA, ADDR_HIGH_BYTE);
        w[2]  = bus_write(IS_DATA, op.x_start);
        w[3]  = bus_write(IS_DATA, ADDR_HIGH_BYTE);
        w[4]  = bus_write(IS_DATA, 8'(op.x_end - 8'd1));
        w[5]  = bus_write(IS_CMD, CMD_ROW_ADDR);
        w[6]  = bus_write(IS_DATA, ADDR_HIGH_BYTE);
        w[7]  = bus_write(IS_DATA, op.y_start);
        w[8]  = bus_write(IS_DATA, ADDR_HIGH_BYTE);
        w[9]  = bus_write(IS_DATA, 8'(op.y_end - 8'd1));
        w[10] = bus_write(IS_CMD, CMD_MEMORY_WRITE);
        n = 11;
      end
      ACT_PIXEL: begin
        w[0] = bus_write(IS_DATA, op.color[15:8]);
        w[1] = bus_write(IS_DATA, op.color[7:0]);
        n = 2;
      end
      ACT_GLYPH: begin
        // msb is the first pixel
        for (int i = 0; i < 8; i++) begin
          px = op.glyph_bits[7 - i] ? fg_shadow : bg_shadow;
          w[2 * i]     = bus_write(IS_DATA, px[15:8]);
          w[2 * i + 1] = bus_write(IS_DATA, px[7:0]);
        end
        n = 16;
      end
      ACT_CMD: begin
        w[0] = bus_write(IS_CMD, op.raw_byte);
        n = 1;
      end
      ACT_PARAM: begin
        w[0] = bus_write(IS_DATA, op.raw_byte);
        n = 1;
      end
      default: begin
        n = 0;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      w[i].last = (i == n - 1);
      pending_writes.push_back(w[i]);
    end
  endfunction

  // bus write check, in order against the oldest prediction
  always @(posedge clk) begin : bus_write_check
    lpgw_out_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        $error("bus write with nothing expected: is_data %0b bus_byte 0x%02h last %0b",
               out_data.is_data, out_data.bus_byte, out_data.last);
        error_count++;
      end else begin
        exp_w = pending_writes.pop_front();
        writes_checked++;
        if (out_data.is_data !== exp_w.is_data) begin
          $error("is_data: expected %0b, actual %0b", exp_w.is_data, out_data.is_data);
          error_count++;
        end
        if (out_data.bus_byte !== exp_w.bus_byte) begin
          $error("bus_byte: expected 0x%02h, actual 0x%02h", exp_w.bus_byte,
                 out_data.bus_byte);
          error_count++;
        end
        if (out_data.last !== exp_w.last) begin
          $error("last: expected %0b, actual %0b", exp_w.last, out_data.last);
          error_count++;
        end
      end
    end
  end

  // one operation transaction; valid stays high for a following back-to-back op
  task automatic send_op(input lpgw_in_t op);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall);
    predict_writes(op);
    if (op.action <= ACT_PARAM) ops_sent++;
  endtask

  // drop valid, let every predicted write come out, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // byte and word values biased toward the extremes
  function automatic logic [7:0] skewed_byte();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] skewed_word();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // all fields random, the unused ones too
  function automatic lpgw_in_t random_op(input logic [2:0] action);
    lpgw_in_t op;
    op.action     = action;
    op.x_start    = skewed_byte();
    op.y_start    = skewed_byte();
    op.x_end      = skewed_byte();
    op.y_end      = skewed_byte();
    op.color      = skewed_word();
    op.glyph_bits = skewed_byte();
    op.raw_byte   = skewed_byte();
    return op;
  endfunction

  // apb write, setup then access; bits 31:16 carry junk that must be dropped
  task automatic cfg_write(input lpgw_reg_e idx, input logic [15:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_FG_COLOR) fg_shadow = value;
    else bg_shadow = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // apb read back against the shadow copy
  task automatic cfg_check(input lpgw_reg_e idx);
    logic [15:0] exp_v;
    exp_v = (idx == REG_FG_COLOR) ? fg_shadow : bg_shadow;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== exp_v) begin
      $error("%s: expected 0x%04h, actual 0x%04h",
             (idx == REG_FG_COLOR) ? "fg_color" : "bg_color", exp_v, prdata[15:0]);
      error_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_colors(input logic [15:0] fg, input logic [15:0] bg);
    cfg_write(REG_FG_COLOR, fg);
    cfg_write(REG_BG_COLOR, bg);
    cfg_check(REG_FG_COLOR);
    cfg_check(REG_BG_COLOR);
    color_settings++;
  endtask

  // registers come up at their reset colors and a glyph uses them
  task automatic test_reset_colors();
    lpgw_in_t op;
    cfg_check(REG_FG_COLOR);
    cfg_check(REG_BG_COLOR);
    color_settings++;
    op = random_op(ACT_GLYPH);
    op.glyph_bits = 8'hA5;
    send_op(op);
    wait_idle();
  endtask

  // window ends at zero wrap to 0xff, ends at one give zero
  task automatic test_window_setup();
    lpgw_in_t op;
    op = random_op(ACT_WINDOW);
    op.x_start = 8'h00;
    op.x_end   = 8'h00;
    op.y_start = 8'h00;
    op.y_end   = 8'h00;
    send_op(op);
    op.x_start = 8'hFF;
    op.x_end   = 8'hFF;
    op.y_start = 8'hFF;
    op.y_end   = 8'h01;
    send_op(op);
    send_op(random_op(ACT_WINDOW));
    wait_idle();
  endtask

  // pixel color extremes and raw command/parameter pass-through
  task automatic test_pixels_and_raw();
    lpgw_in_t op;
    op = random_op(ACT_PIXEL);
    op.color = 16'h0000;
    send_op(op);
    op.color = 16'hFFFF;
    send_op(op);
    send_op(random_op(ACT_PIXEL));
    op = random_op(ACT_CMD);
    op.raw_byte = 8'h00;
    send_op(op);
    op.raw_byte = 8'hFF;
    send_op(op);
    op = random_op(ACT_PARAM);
    op.raw_byte = 8'h00;
    send_op(op);
    op.raw_byte = 8'hFF;
    send_op(op);
    wait_idle();
  endtask

  // glyph expansion with extreme colors, both polarities
  task automatic test_glyph_colors();
    lpgw_in_t op;
    set_colors(16'h0000, 16'hFFFF);
    op = random_op(ACT_GLYPH);
    op.glyph_bits = 8'h00;
    send_op(op);
    op.glyph_bits = 8'hFF;
    send_op(op);
    op.glyph_bits = 8'h80;
    send_op(op);
    op.glyph_bits = 8'h01;
    send_op(op);
    wait_idle();
    set_colors(16'hFFFF, 16'h0000);
    op.glyph_bits = 8'h5A;
    send_op(op);
    wait_idle();
  endtask

  // undefined actions emit nothing, the next op must come out alone
  task automatic test_unknown_actions();
    lpgw_in_t op;
    for (int a = ACT_UNKNOWN_FIRST; a <= ACT_UNKNOWN_LAST; a++) begin
      send_op(random_op(3'(a)));
    end
    op = random_op(ACT_PARAM);
    send_op(op);
    wait_idle();
  endtask

  // mostly window-then-draw sequences, some command runs, some noise;
  // several color settings and receiver patterns, bursty sender
  task automatic test_random_traffic();
    lpgw_in_t op;
    lpgw_in_t seq[$];
    int       sent;
    int       kind;
    int       gap;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          set_colors(16'($urandom), 16'($urandom));
          stall_mode = STALL_LIGHT;
        end
        1: begin
          set_colors(16'hFFFF, 16'h0000);
          stall_mode = STALL_BURSTY;
        end
        2: begin
          set_colors(16'($urandom), 16'($urandom));
          stall_mode = STALL_NONE;
        end
        default: begin
          set_colors(16'h0000, 16'hFFFF);
          stall_mode = STALL_BURSTY;
        end
      endcase
      sent = 0;
      burst_left = $urandom_range(1, 10);
      while (sent < PHASE_OPS) begin
        seq.delete();
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          seq.push_back(random_op(ACT_WINDOW));
          repeat ($urandom_range(1, 6)) begin
            seq.push_back(random_op($urandom_range(0, 1) ? ACT_PIXEL : ACT_GLYPH));
          end
        end else if (kind < 8) begin
          seq.push_back(random_op(ACT_CMD));
          repeat ($urandom_range(0, 4)) seq.push_back(random_op(ACT_PARAM));
        end else begin
          // noise, unknown codes included, draws without a window
          repeat ($urandom_range(1, 3)) begin
            seq.push_back(random_op(3'($urandom_range(0, ACT_UNKNOWN_LAST))));
          end
        end
        while (seq.size() != 0) begin
          op = seq.pop_front();
          send_op(op);
          if (op.action <= ACT_PARAM) sent++;
          // end of a burst: random idle gap, sometimes none
          burst_left--;
          if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
              @(negedge clk);
              in_valid <= 1'b0;
              repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 10);
          end
        end
      end
      wait_idle();
    end
  endtask

  initial begin : main_sequence
    // reset once, released on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_reset_colors();
    test_window_setup();
    stall_mode = STALL_LIGHT;
    test_pixels_and_raw();
    test_glyph_colors();
    test_unknown_actions();
    test_random_traffic();

    stall_mode = STALL_NONE;
    wait_idle();
    if (pending_writes.size() != 0) begin
      $error("%0d predicted writes never came out", pending_writes.size());
      error_count++;
    end

    $display("covered window setup, pixels, glyph bytes, raw bytes and unknown actions:");
    $display("  %0d operations, %0d bus writes checked, %0d color settings, %0d cycles",
             ops_sent, writes_checked, color_settings, cycle_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/lpgw_pkg.sv
design/lpgw_cfg.sv
design/lpgw_byte_gen.sv
design/lcd_parallel_window_glyph_writer_core.sv
bench/lcd_parallel_window_glyph_writer_core_test.sv
